// ===== rtl/line_segment_clipper_defines.svh =====
// ----------------------------------------------------------------------------
// line segment clipper assertion macros
// shared clocked assertion forms, sampled on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_CLIPPER_DEFINES_SVH

// same-cycle implication
`define LSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// types, codes and microprogram of the line segment clipper
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

    localparam int unsigned COORD_WIDTH = 16;
    localparam int unsigned MAX_STEPS   = 4;

    typedef logic [3:0] t_outcode;
    typedef logic [2:0] t_step;
    typedef logic [1:0] t_reg_idx;
    typedef logic [2:0] t_pc;

    localparam t_outcode OC_LEFT   = 4'b0001;
    localparam t_outcode OC_RIGHT  = 4'b0010;
    localparam t_outcode OC_BOTTOM = 4'b0100;
    localparam t_outcode OC_TOP    = 4'b1000;

    localparam t_reg_idx REG_X_MIN = 2'd0;
    localparam t_reg_idx REG_X_MAX = 2'd1;
    localparam t_reg_idx REG_Y_MIN = 2'd2;
    localparam t_reg_idx REG_Y_MAX = 2'd3;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_TEST,
        OP_SETUP,
        OP_MUL,
        OP_DIVLD,
        OP_DIVSTEP,
        OP_UPDATE,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        CND_NEXT,
        CND_ALWAYS,
        CND_NO_INPUT,
        CND_CLIP_END,
        CND_DIV_MORE,
        CND_OUT_BUSY
    } t_cond;

    // jump to target when cond holds, else fall through to the next word
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctl;

    typedef struct packed {
        logic clip_end;
        logic div_more;
    } t_dp_status;

    localparam t_pc PC_LOAD    = 3'd0;
    localparam t_pc PC_TEST    = 3'd1;
    localparam t_pc PC_SETUP   = 3'd2;
    localparam t_pc PC_MUL     = 3'd3;
    localparam t_pc PC_DIVLD   = 3'd4;
    localparam t_pc PC_DIVSTEP = 3'd5;
    localparam t_pc PC_UPDATE  = 3'd6;
    localparam t_pc PC_FINISH  = 3'd7;

    // microprogram; the word after finish wraps to load
    function automatic t_ctl ucode_rom(t_pc pc);
        t_ctl w;
        unique case (pc)
            PC_LOAD:    w = '{op: OP_LOAD,    cond: CND_NO_INPUT, target: PC_LOAD};
            PC_TEST:    w = '{op: OP_TEST,    cond: CND_CLIP_END, target: PC_FINISH};
            PC_SETUP:   w = '{op: OP_SETUP,   cond: CND_NEXT,     target: PC_LOAD};
            PC_MUL:     w = '{op: OP_MUL,     cond: CND_NEXT,     target: PC_LOAD};
            PC_DIVLD:   w = '{op: OP_DIVLD,   cond: CND_NEXT,     target: PC_LOAD};
            PC_DIVSTEP: w = '{op: OP_DIVSTEP, cond: CND_DIV_MORE, target: PC_DIVSTEP};
            PC_UPDATE:  w = '{op: OP_UPDATE,  cond: CND_ALWAYS,   target: PC_TEST};
            PC_FINISH:  w = '{op: OP_FINISH,  cond: CND_OUT_BUSY, target: PC_FINISH};
            default:    w = '{op: OP_LOAD,    cond: CND_NO_INPUT, target: PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lsc_sequencer.sv =====
// ----------------------------------------------------------------------------
// lsc_sequencer
// step counter over the microprogram table with conditional jumps
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_segment_clipper_defines.svh"

module lsc_sequencer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_busy,
    input  lsc_pkg::t_dp_status   i_status,
    output lsc_pkg::t_ctl         o_ctl
);

    lsc_pkg::t_pc r_pc;
    lsc_pkg::t_pc n_pc;
    logic         w_jump;

    assign o_ctl = lsc_pkg::ucode_rom(r_pc);

    always_comb begin
        unique case (o_ctl.cond)
            lsc_pkg::CND_NEXT:     w_jump = 1'b0;
            lsc_pkg::CND_ALWAYS:   w_jump = 1'b1;
            lsc_pkg::CND_NO_INPUT: w_jump = !i_in_valid;
            lsc_pkg::CND_CLIP_END: w_jump = i_status.clip_end;
            lsc_pkg::CND_DIV_MORE: w_jump = i_status.div_more;
            lsc_pkg::CND_OUT_BUSY: w_jump = i_out_busy;
            default:               w_jump = 1'b0;
        endcase
        n_pc = w_jump ? o_ctl.target : lsc_pkg::t_pc'(r_pc + lsc_pkg::t_pc'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= lsc_pkg::PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    `LSC_ASSERT_NXT(a_load_to_test, (o_ctl.op == lsc_pkg::OP_LOAD) && i_in_valid, o_ctl.op == lsc_pkg::OP_TEST, "accepted item did not start the test")
    `LSC_ASSERT_NXT(a_update_to_test, o_ctl.op == lsc_pkg::OP_UPDATE, o_ctl.op == lsc_pkg::OP_TEST, "update did not return to the test")

endmodule

`default_nettype wire

// ===== rtl/lsc_datapath.sv =====
// ----------------------------------------------------------------------------
// lsc_datapath
// window registers, endpoints, outcodes, multiplier and serial divider
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_segment_clipper_defines.svh"

module lsc_datapath #(
    parameter int unsigned COORD_WIDTH = lsc_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsc_pkg::t_ctl                 i_ctl,
    input  logic                          i_in_fire,
    input  logic                          i_cfg_we,
    input  lsc_pkg::t_reg_idx             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output lsc_pkg::t_dp_status           o_status,
    output logic                          o_visible,
    output logic signed [COORD_WIDTH-1:0] o_start_x,
    output logic signed [COORD_WIDTH-1:0] o_start_y,
    output logic signed [COORD_WIDTH-1:0] o_end_x,
    output logic signed [COORD_WIDTH-1:0] o_end_y
);

    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned DW = W + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned CW = $clog2(DW + 1);

    logic signed [W-1:0] r_xmin, r_xmax, r_ymin, r_ymax;
    logic signed [W-1:0] r_sx, r_sy, r_ex, r_ey;
    lsc_pkg::t_step      r_step;
    logic [CW-1:0]       r_cnt;

    logic                r_y_axis;
    logic                r_use_start;
    logic                r_neg;
    logic signed [W-1:0] r_edge;
    logic signed [W-1:0] r_base;
    logic [DW-1:0]       r_mag_o, r_mag_a, r_mag_d;
    logic [PW-1:0]       r_prod;
    logic [DW-1:0]       r_rem, r_quo;

    lsc_pkg::t_outcode    w_sc, w_ec, w_sel;
    logic                 w_accept, w_reject, w_use_start, w_y_axis;
    logic signed [W-1:0]  w_edge, w_s_o, w_e_o, w_s_a, w_e_a;
    logic signed [DW-1:0] w_num_o, w_num_a, w_den;
    logic [DW:0]          w_shift, w_trial;
    logic [DW-1:0]        w_q;
    logic signed [DW:0]   w_qs, w_sum;
    logic signed [W-1:0]  w_new;

    function automatic lsc_pkg::t_outcode outcode(
        logic signed [W-1:0] x, logic signed [W-1:0] y,
        logic signed [W-1:0] xmin, logic signed [W-1:0] xmax,
        logic signed [W-1:0] ymin, logic signed [W-1:0] ymax);
        lsc_pkg::t_outcode c;
        c = '0;
        if (x < xmin) begin
            c = c | lsc_pkg::OC_LEFT;
        end else if (x > xmax) begin
            c = c | lsc_pkg::OC_RIGHT;
        end
        if (y < ymin) begin
            c = c | lsc_pkg::OC_BOTTOM;
        end else if (y > ymax) begin
            c = c | lsc_pkg::OC_TOP;
        end
        return c;
    endfunction

    function automatic logic signed [DW-1:0] ext1(logic signed [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic [DW-1:0] mag(logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    always_comb begin
        w_sc        = outcode(r_sx, r_sy, r_xmin, r_xmax, r_ymin, r_ymax);
        w_ec        = outcode(r_ex, r_ey, r_xmin, r_xmax, r_ymin, r_ymax);
        w_accept    = (w_sc | w_ec) == '0;
        w_reject    = (w_sc & w_ec) != '0;
        w_use_start = w_sc != '0;
        w_sel       = w_use_start ? w_sc : w_ec;
        w_y_axis    = (w_sel & (lsc_pkg::OC_TOP | lsc_pkg::OC_BOTTOM)) != '0;
        if (w_y_axis) begin
            w_edge = ((w_sel & lsc_pkg::OC_TOP) != '0) ? r_ymax : r_ymin;
            w_s_a  = r_sy;
            w_e_a  = r_ey;
            w_s_o  = r_sx;
            w_e_o  = r_ex;
        end else begin
            w_edge = ((w_sel & lsc_pkg::OC_RIGHT) != '0) ? r_xmax : r_xmin;
            w_s_a  = r_sx;
            w_e_a  = r_ex;
            w_s_o  = r_sy;
            w_e_o  = r_ey;
        end
        w_num_o = ext1(w_e_o) - ext1(w_s_o);
        w_num_a = ext1(w_edge) - ext1(w_s_a);
        w_den   = ext1(w_e_a) - ext1(w_s_a);

        // restoring division, one quotient bit per step
        w_shift = {r_rem, r_quo[DW-1]};
        w_trial = w_shift - {1'b0, r_mag_d};

        // crossing = base + signed quotient, a zero divisor gives a zero quotient
        w_q   = (r_mag_d == '0) ? '0 : r_quo;
        w_qs  = r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
        w_sum = $signed({r_base[W-1], r_base[W-1], r_base}) + w_qs;
        w_new = w_sum[W-1:0];
    end

    assign o_status.clip_end = w_accept || w_reject
                            || (r_step == lsc_pkg::t_step'(lsc_pkg::MAX_STEPS));
    assign o_status.div_more = r_cnt != CW'(1);
    assign o_visible = w_accept;
    assign o_start_x = r_sx;
    assign o_start_y = r_sy;
    assign o_end_x   = r_ex;
    assign o_end_y   = r_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin <= '0;
            r_xmax <= {1'b0, {(W-1){1'b1}}};
            r_ymin <= '0;
            r_ymax <= {1'b0, {(W-1){1'b1}}};
            r_step <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lsc_pkg::REG_X_MIN: r_xmin <= $signed(i_cfg_data);
                    lsc_pkg::REG_X_MAX: r_xmax <= $signed(i_cfg_data);
                    lsc_pkg::REG_Y_MIN: r_ymin <= $signed(i_cfg_data);
                    lsc_pkg::REG_Y_MAX: r_ymax <= $signed(i_cfg_data);
                    default: ;
                endcase
            end
            unique case (i_ctl.op)
                lsc_pkg::OP_LOAD:    if (i_in_fire) r_step <= '0;
                lsc_pkg::OP_UPDATE:  r_step <= lsc_pkg::t_step'(r_step + lsc_pkg::t_step'(1));
                lsc_pkg::OP_DIVLD:   r_cnt <= CW'(DW);
                lsc_pkg::OP_DIVSTEP: r_cnt <= CW'(r_cnt - CW'(1));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            lsc_pkg::OP_LOAD: begin
                if (i_in_fire) begin
                    r_sx <= i_start_x;
                    r_sy <= i_start_y;
                    r_ex <= i_end_x;
                    r_ey <= i_end_y;
                end
            end
            lsc_pkg::OP_SETUP: begin
                r_y_axis    <= w_y_axis;
                r_use_start <= w_use_start;
                r_edge      <= w_edge;
                r_base      <= w_s_o;
                r_mag_o     <= mag(w_num_o);
                r_mag_a     <= mag(w_num_a);
                r_mag_d     <= mag(w_den);
                r_neg       <= w_num_o[DW-1] ^ w_num_a[DW-1] ^ w_den[DW-1];
            end
            lsc_pkg::OP_MUL: begin
                r_prod <= r_mag_o * r_mag_a;
            end
            lsc_pkg::OP_DIVLD: begin
                r_rem <= r_prod[PW-1:DW];
                r_quo <= r_prod[DW-1:0];
            end
            lsc_pkg::OP_DIVSTEP: begin
                if (!w_trial[DW]) begin
                    r_rem <= w_trial[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
            end
            lsc_pkg::OP_UPDATE: begin
                if (r_use_start) begin
                    r_sx <= r_y_axis ? w_new : r_edge;
                    r_sy <= r_y_axis ? r_edge : w_new;
                end else begin
                    r_ex <= r_y_axis ? w_new : r_edge;
                    r_ey <= r_y_axis ? r_edge : w_new;
                end
            end
            default: ;
        endcase
    end

    `LSC_ASSERT_IMP(a_step_bound, 1'b1, r_step <= lsc_pkg::t_step'(lsc_pkg::MAX_STEPS), "clip step count past its limit")
    `LSC_ASSERT_NXT(a_divld_count, i_ctl.op == lsc_pkg::OP_DIVLD, r_cnt == CW'(DW), "divider count not loaded")

endmodule

`default_nettype wire

// ===== rtl/line_segment_clipper.sv =====
// ----------------------------------------------------------------------------
// line_segment_clipper
// cohen-sutherland clipping of one 2d segment against a programmable window
// ----------------------------------------------------------------------------
// One segment per item. A microcoded sequencer drives a datapath with one
// multiplier and a restoring divider that yields one quotient bit per cycle;
// each clip step runs setup, multiply, divider load, COORD_WIDTH+1 divide
// steps, update and outcode test, with 0 to 4 clip steps per item. A new
// segment is taken only after the last result is loaded into the output
// register. Coordinates are signed fixed point; the fraction bits cancel in
// the crossing ratio, so the fraction width does not enter the logic. A
// rejected segment returns zero endpoints. The user must write window
// registers only while the block is idle; the block does not enforce this.
`default_nettype none
`include "line_segment_clipper_defines.svh"

module line_segment_clipper #(
    parameter int unsigned COORD_WIDTH = lsc_pkg::COORD_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  lsc_pkg::t_reg_idx                     i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]                i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // visible
    output logic                                  m_axis_tuser
);

    localparam int unsigned W     = COORD_WIDTH;
    localparam int unsigned DATAW = ((4 * W + 7) / 8) * 8;

    lsc_pkg::t_ctl       w_ctl;
    lsc_pkg::t_dp_status w_status;
    logic                w_in_fire;
    logic                w_out_busy;
    logic                w_out_load;
    logic                w_visible;
    logic signed [W-1:0] w_sx, w_sy, w_ex, w_ey;

    logic                r_m_valid;
    logic                r_m_user;
    logic [DATAW-1:0]    r_m_data;

    assign s_axis_tready = w_ctl.op == lsc_pkg::OP_LOAD;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_busy    = r_m_valid && !m_axis_tready;
    assign w_out_load    = (w_ctl.op == lsc_pkg::OP_FINISH) && !w_out_busy;

    lsc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_busy (w_out_busy),
        .i_status   (w_status),
        .o_ctl      (w_ctl)
    );

    lsc_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_in_fire  (w_in_fire),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start_x  ($signed(s_axis_tdata[W-1:0])),
        .i_start_y  ($signed(s_axis_tdata[2*W-1:W])),
        .i_end_x    ($signed(s_axis_tdata[3*W-1:2*W])),
        .i_end_y    ($signed(s_axis_tdata[4*W-1:3*W])),
        .o_status   (w_status),
        .o_visible  (w_visible),
        .o_start_x  (w_sx),
        .o_start_y  (w_sy),
        .o_end_x    (w_ex),
        .o_end_y    (w_ey)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_user <= w_visible;
            r_m_data <= w_visible ? DATAW'({w_ey, w_ex, w_sy, w_sx}) : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tdata  = r_m_data;

    `LSC_ASSERT_IMP(a_out_from_finish, $rose(m_axis_tvalid), $past(w_ctl.op == lsc_pkg::OP_FINISH), "result item without a finish step")
    `LSC_ASSERT_IMP(a_no_take_in_work, w_ctl.op != lsc_pkg::OP_LOAD, !s_axis_tready, "input taken while a segment is in work")

endmodule

`default_nettype wire
